### src/asidec_pkg.sv
// asidec_pkg: shared types, constants and lookup tables of the adpcm step index decoder
`default_nettype none
package asidec_pkg;

	localparam int unsigned SampleWidth = 16;
	localparam int unsigned IndexWidth  = 7;
	localparam int unsigned StepWidth   = 15;
	localparam int unsigned DiffWidth   = 18;

	localparam logic [IndexWidth-1:0] IdxInit = 7'd44;
	localparam logic [IndexWidth-1:0] IdxTop  = 7'd88;
	localparam logic [IndexWidth-1:0] IdxJump = 7'd8;

	localparam logic [7:0] CmdSkip   = 8'h82;
	localparam logic [7:0] CmdRepeat = 8'h80;
	localparam logic [7:0] CmdUp     = 8'h81;

	localparam int unsigned CmdBit  = 7;
	localparam int unsigned SignBit = 6;

	localparam logic       OpLoad = 1'b0;
	localparam logic       OpCode = 1'b1;

	localparam logic       CfgChannelCount = 1'b0;
	localparam logic       CfgBaseShift    = 1'b1;
	localparam int unsigned CfgDataWidth   = 4;

	localparam logic signed [SampleWidth+2:0] PcmLow  = -19'sd32768;
	localparam logic signed [SampleWidth+2:0] PcmHigh = 19'sd32767;

	typedef logic signed [SampleWidth-1:0] sample_t;
	typedef logic [IndexWidth-1:0]          index_t;

	typedef struct packed {
		sample_t sample;
		index_t  index;
	} entry_t;

	localparam entry_t EntryReset = '{sample: '0, index: IdxInit};

	function automatic logic [StepWidth-1:0] step_lookup(input index_t idx);
		logic [StepWidth-1:0] s;
		unique case (idx)
			7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
			7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
			7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
			7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
			7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
			7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
			7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
			7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
			7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
			7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
			7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
			7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
			7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
			7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
			7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
			7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
			7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
			7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
			7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
			7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
			7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
			7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
			7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
			7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
			7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
			7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
			7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
			7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
			7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
			7'd87: s = 15'd29794;
			default: s = 15'd32767;
		endcase
		return s;
	endfunction

	function automatic logic signed [4:0] adapt_lookup(input logic [4:0] code);
		logic signed [4:0] a;
		if (!code[0]) begin
			a = -5'sd1;
		end else begin
			unique case (code[4:1])
				4'd0:  a = 5'sd0;  4'd1:  a = 5'sd4;  4'd2:  a = 5'sd2;  4'd3:  a = 5'sd6;
				4'd4:  a = 5'sd1;  4'd5:  a = 5'sd5;  4'd6:  a = 5'sd3;  4'd7:  a = 5'sd7;
				4'd8:  a = 5'sd1;  4'd9:  a = 5'sd5;  4'd10: a = 5'sd3;  4'd11: a = 5'sd7;
				4'd12: a = 5'sd2;  4'd13: a = 5'sd4;  4'd14: a = 5'sd6;
				default: a = 5'sd8;
			endcase
		end
		return a;
	endfunction

endpackage
`default_nettype wire

### src/asidec_if.sv
// asidec channel interfaces: code words in, pcm words out
`default_nettype none
interface asidec_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [7:0]  code_byte;
	logic signed [15:0] raw_sample;
	logic        load_channel;

	modport source (output valid, output op, output code_byte, output raw_sample,
		output load_channel, input ready);
	modport sink (input valid, input op, input code_byte, input raw_sample,
		input load_channel, output ready);
endinterface

interface asidec_out_if;
	logic        valid;
	logic        ready;
	logic signed [15:0] pcm_sample;
	logic        sample_channel;

	modport source (output valid, output pcm_sample, output sample_channel, input ready);
	modport sink (input valid, input pcm_sample, input sample_channel, output ready);
endinterface
`default_nettype wire

### src/adpcm_step_index_decoder_core.sv
// adpcm_step_index_decoder_core: ima-style adpcm decoder, mono or stereo, 16-bit pcm out
//
// code_chan takes one word per cycle unless stalled: a load (op 0) presets a channel's
// sample and step index and echoes the sample; a code byte is a command or a data byte.
// pcm_chan gives one word for each load, repeat command and data byte; skip and
// step up/down commands give none.
// cfg_we/cfg_idx/cfg_wdata write channel_count (index 0) and base_shift (index 1);
// write only while no word is in flight.
// per-channel sample and step index sit in a two-entry memory that is read into the
// read register as a word is taken; stage 1 computes and writes back, with a bypass
// into the read register when the next word hits the same entry.
// a result goes from the read register through stage 1 into the output register on pcm_chan.
// throughput: one code word per cycle unless stalled; set by the state read-modify-write.
// reset clears the channel pointer and marks both memory entries as unwritten, so
// they read as sample 0, step index 44; configuration returns to mono, shift 0.
// a stalled pcm_chan holds its word; the next word with a result waits in stage 1
// and further code words wait until the output register drains.
`default_nettype none
module adpcm_step_index_decoder_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire                                 cfg_idx,
	input  wire [asidec_pkg::CfgDataWidth-1:0]  cfg_wdata,
	asidec_in_if.sink                           code_chan,
	asidec_out_if.source                        pcm_chan
);
	import asidec_pkg::*;

	logic [1:0] chan_count_q;
	logic [3:0] base_shift_q;
	logic       cur_ch_q;

	entry_t     mem_q [2];
	logic [1:0] mem_valid_q;

	logic       valid_s1;
	logic       op_s1;
	logic [7:0] code_s1;
	sample_t    raw_s1;
	logic       ch_s1;
	entry_t     rd_s1;

	logic       valid_s2;
	sample_t    sample_s2;
	logic       ch_s2;

	logic       accept;
	logic       rd_addr;
	logic       has_res;
	logic       go_s1;
	logic       wr_en;
	entry_t     wr_data;
	sample_t    res_sample;
	logic       is_cmd;
	logic       rotates;
	logic       next_ch;

	index_t               idx_c;
	logic [StepWidth-1:0] step;
	logic [DiffWidth-1:0] diff;
	logic signed [SampleWidth+2:0] sum;
	sample_t              data_sample;
	logic signed [7:0]    idx_adj;
	index_t               data_idx;
	index_t               up_idx;
	index_t               down_idx;
	index_t               rep_idx;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_count_q <= 2'd1;
			base_shift_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CfgChannelCount: chan_count_q <= cfg_wdata[1:0];
				CfgBaseShift:    base_shift_q <= cfg_wdata;
				default:         ;
			endcase
		end
	end

	// handshake
	assign has_res = (op_s1 == OpLoad) || (code_s1 == CmdRepeat) || !code_s1[CmdBit];
	assign go_s1   = valid_s1 && (!has_res || !valid_s2 || pcm_chan.ready);
	assign code_chan.ready = !valid_s1 || go_s1;
	assign accept  = code_chan.valid && code_chan.ready;
	assign rd_addr = (code_chan.op == OpLoad) ? code_chan.load_channel : cur_ch_q;

	// channel rotation
	assign is_cmd  = code_chan.code_byte[CmdBit];
	assign rotates = !is_cmd || (code_chan.code_byte == CmdSkip)
		|| (code_chan.code_byte == CmdRepeat);
	always_comb begin
		next_ch = cur_ch_q;
		if (code_chan.op == OpLoad) begin
			next_ch = 1'b0;
		end else if (rotates) begin
			next_ch = chan_count_q[1] ? ~cur_ch_q : 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_ch_q <= 1'b0;
		end else if (accept) begin
			cur_ch_q <= next_ch;
		end
	end

	// stage 1 datapath
	assign idx_c = (rd_s1.index > IdxTop) ? IdxTop : rd_s1.index;
	assign step  = step_lookup(idx_c);

	always_comb begin
		diff = DiffWidth'(step) >> base_shift_q;
		for (int i = 0; i < 6; i++) begin
			if (code_s1[i]) begin
				diff = diff + (DiffWidth'(step) >> i);
			end
		end
	end

	always_comb begin
		if (code_s1[SignBit]) begin
			sum = (SampleWidth+3)'(rd_s1.sample) - $signed({1'b0, diff});
		end else begin
			sum = (SampleWidth+3)'(rd_s1.sample) + $signed({1'b0, diff});
		end
		if (sum < PcmLow) begin
			data_sample = PcmLow[SampleWidth-1:0];
		end else if (sum > PcmHigh) begin
			data_sample = PcmHigh[SampleWidth-1:0];
		end else begin
			data_sample = sum[SampleWidth-1:0];
		end
	end

	always_comb begin
		idx_adj = $signed({1'b0, idx_c}) + 8'(adapt_lookup(code_s1[4:0]));
		if (idx_adj < 8'sd0) begin
			data_idx = '0;
		end else if (idx_adj > $signed({1'b0, IdxTop})) begin
			data_idx = IdxTop;
		end else begin
			data_idx = idx_adj[IndexWidth-1:0];
		end
	end

	assign up_idx   = (rd_s1.index >= IdxTop - IdxJump) ? IdxTop : rd_s1.index + IdxJump;
	assign down_idx = (rd_s1.index < IdxJump) ? '0 : rd_s1.index - IdxJump;
	assign rep_idx  = (rd_s1.index == '0) ? '0 : rd_s1.index - 7'd1;

	always_comb begin
		wr_data    = rd_s1;
		res_sample = rd_s1.sample;
		if (op_s1 == OpLoad) begin
			wr_data    = '{sample: raw_s1, index: IdxInit};
			res_sample = raw_s1;
		end else if (!code_s1[CmdBit]) begin
			wr_data    = '{sample: data_sample, index: data_idx};
			res_sample = data_sample;
		end else if (code_s1 == CmdRepeat) begin
			wr_data.index = rep_idx;
		end else if (code_s1 == CmdUp) begin
			wr_data.index = up_idx;
		end else begin
			wr_data.index = down_idx;
		end
	end

	assign wr_en = go_s1 && ((op_s1 == OpLoad) || (code_s1 != CmdSkip));

	// state memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[ch_s1] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_valid_q <= '0;
		end else if (wr_en) begin
			mem_valid_q[ch_s1] <= 1'b1;
		end
	end

	// read register with bypass from the write-back
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= code_chan.op;
			code_s1 <= code_chan.code_byte;
			raw_s1  <= code_chan.raw_sample;
			ch_s1   <= rd_addr;
			if (wr_en && (ch_s1 == rd_addr)) begin
				rd_s1 <= wr_data;
			end else if (mem_valid_q[rd_addr]) begin
				rd_s1 <= mem_q[rd_addr];
			end else begin
				rd_s1 <= EntryReset;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (code_chan.ready) begin
			valid_s1 <= code_chan.valid;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go_s1 && has_res) begin
			valid_s2 <= 1'b1;
		end else if (pcm_chan.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && has_res) begin
			sample_s2 <= res_sample;
			ch_s2     <= ch_s1;
		end
	end

	assign pcm_chan.valid          = valid_s2;
	assign pcm_chan.pcm_sample     = sample_s2;
	assign pcm_chan.sample_channel = ch_s2;

endmodule
`default_nettype wire
